>>> rtl/mie_pkg.sv
// Shared types and microcode program for the modular inverse sequencer.
// No dependencies; imported by mie_useq, mie_dpath and the top level.
package mie_pkg;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_UPDATE,
		OP_FINISH
	} dp_op_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_START_N,
		JC_A_ZERO,
		JC_CNT_NZ
	} jump_cond_t;

	typedef logic [2:0] upc_t;

	localparam upc_t STEP_IDLE   = 3'd0;
	localparam upc_t STEP_TEST   = 3'd1;
	localparam upc_t STEP_DINIT  = 3'd2;
	localparam upc_t STEP_DSTEP  = 3'd3;
	localparam upc_t STEP_UPDATE = 3'd4;
	localparam upc_t STEP_FINISH = 3'd5;

	typedef struct packed {
		dp_op_t     op;
		jump_cond_t jc;
		upc_t       target;
	} ucode_t;

	typedef struct packed {
		dp_op_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic a_zero;
		logic cnt_nz;
	} dp_status_t;

	function automatic ucode_t ucode_rom(input upc_t addr);
		ucode_t w;
		unique case (addr)
			STEP_IDLE:   w = '{op: OP_LOAD,     jc: JC_START_N, target: STEP_IDLE};
			STEP_TEST:   w = '{op: OP_NONE,     jc: JC_A_ZERO,  target: STEP_FINISH};
			STEP_DINIT:  w = '{op: OP_DIV_INIT, jc: JC_NEXT,    target: STEP_IDLE};
			STEP_DSTEP:  w = '{op: OP_DIV_STEP, jc: JC_CNT_NZ,  target: STEP_DSTEP};
			STEP_UPDATE: w = '{op: OP_UPDATE,   jc: JC_ALWAYS,  target: STEP_TEST};
			STEP_FINISH: w = '{op: OP_FINISH,   jc: JC_ALWAYS,  target: STEP_IDLE};
			default:     w = '{op: OP_NONE,     jc: JC_ALWAYS,  target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/mie_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on mie_pkg.
module mie_useq
	import mie_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_ctrl_t   ctrl,
	output logic       busy
);

	upc_t   upc_q;
	upc_t   upc_next;
	ucode_t uw;
	logic   take;

	assign uw = ucode_rom(upc_q);

	always_comb begin
		unique case (uw.jc)
			JC_NEXT:    take = 1'b0;
			JC_ALWAYS:  take = 1'b1;
			JC_START_N: take = !start;
			JC_A_ZERO:  take = status.a_zero;
			JC_CNT_NZ:  take = status.cnt_nz;
			default:    take = 1'b1;
		endcase
	end

	always_comb begin
		upc_next = take ? uw.target : upc_t'(upc_q + 3'd1);
	end

	always_comb begin
		ctrl.op = uw.op;
		if (uw.jc == JC_START_N && !start) begin
			ctrl.op = OP_NONE;
		end
	end

	assign busy = (upc_q != STEP_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

>>> rtl/mie_dpath.sv
// Datapath: operand registers, bit-serial divider with quotient-times-coefficient
// accumulator, coefficient pair and result registers. Depends on mie_pkg.
module mie_dpath
	import mie_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_ctrl_t         ctrl,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] modulus,
	output dp_status_t       status,
	output logic             done,
	output logic [WIDTH-1:0] inverse,
	output logic [WIDTH-1:0] divisor,
	output logic             coprime
);

	localparam int CW    = WIDTH + 2;
	localparam int CNT_W = $clog2(WIDTH);

	logic [WIDTH-1:0]        a_q, m_q, mod_q, rem_q, quo_q;
	logic signed [CW-1:0]    cp_q, cc_q, p_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [WIDTH-1:0]        inverse_q, divisor_q;
	logic                    coprime_q, done_q;

	logic [WIDTH:0]          rem_sh, a_ext, rem_sub;
	logic                    ge;
	logic signed [CW-1:0]    mod_ext, inv_fix;

	assign rem_sh  = {rem_q, quo_q[WIDTH-1]};
	assign a_ext   = {1'b0, a_q};
	assign ge      = (rem_sh >= a_ext);
	assign rem_sub = rem_sh - a_ext;
	assign mod_ext = {{(CW-WIDTH){1'b0}}, mod_q};
	assign inv_fix = cp_q[CW-1] ? (cp_q + mod_ext) : cp_q;

	assign status.a_zero = (a_q == '0);
	assign status.cnt_nz = (cnt_q != '0);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				a_q   <= value;
				m_q   <= modulus;
				mod_q <= modulus;
				cp_q  <= '0;
				cc_q  <= CW'(1);
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= m_q;
				p_q   <= '0;
				cnt_q <= CNT_W'(WIDTH - 1);
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
				p_q   <= (p_q <<< 1) + (ge ? cc_q : '0);
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_UPDATE: begin
				cp_q <= cc_q;
				cc_q <= cp_q - p_q;
				m_q  <= a_q;
				a_q  <= rem_q;
			end
			OP_FINISH: begin
				inverse_q <= inv_fix[WIDTH-1:0];
				divisor_q <= m_q;
				coprime_q <= (m_q == WIDTH'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == OP_FINISH);
		end
	end

	assign done    = done_q;
	assign inverse = inverse_q;
	assign divisor = divisor_q;
	assign coprime = coprime_q;

endmodule

>>> rtl/modular_inverse_ext_euclid_top.sv
// Modular inverse by extended Euclid, microcoded: one division of WIDTH bit-serial
// steps per Euclid iteration (about 1 + 1.5*WIDTH iterations worst case); one item
// at a time, busy while running.
// done pulses one cycle with the result; the receiver cannot stall.
// Async active-low reset returns the sequencer to idle and clears done.
// Depends on mie_pkg, mie_useq, mie_dpath.
module modular_inverse_ext_euclid_top
	import mie_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] modulus,
	output logic             done,
	output logic [WIDTH-1:0] inverse,
	output logic [WIDTH-1:0] divisor,
	output logic             coprime
);

	dp_ctrl_t   ctrl;
	dp_status_t status;

	mie_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	mie_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.value   (value),
		.modulus (modulus),
		.status  (status),
		.done    (done),
		.inverse (inverse),
		.divisor (divisor),
		.coprime (coprime)
	);

endmodule
